/* sv/assert_macros.svh */
// Assertion macros shared by the parser RTL.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define MSP_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/msp_pkg.sv */
// Shared types and constants for the MSP v1 frame parser.
// No dependencies.
package msp_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;

	localparam logic [7:0] MAX_LEN_RESET = 8'hFF;

	localparam int OUT_BITS  = 69;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
	localparam int OUT_W     = OUT_BYTES * 8;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_DOLLAR = 3'd1,
		PH_M      = 3'd2,
		PH_ARROW  = 3'd3,
		PH_LENGTH = 3'd4,
		PH_BODY   = 3'd5
	} phase_t;

	typedef struct packed {
		logic [15:0] errors_seen;
		logic [15:0] frames_received;
		logic        frame_ok;
		logic        packet_is_reply;
		logic [7:0]  command_code;
		logic [7:0]  payload_length;
		logic [7:0]  payload_index;
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        frame_error;
		logic        accepted;
	} result_t;

endpackage

/* sv/msp_core.sv */
// Parser state and single-pass step logic for one received byte.
// Depends on msp_pkg.
module msp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	output msp_pkg::result_t res
);

	msp_pkg::phase_t phase_q, phase_d;
	logic        reply_q, reply_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  offset_q, offset_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] good_q, good_d;
	logic [15:0] bad_q, bad_d;
	logic [7:0]  max_len_q;
	logic        ok, pv, fok;

	// byte classification for the current phase
	always_comb begin
		ok  = 1'b0;
		pv  = 1'b0;
		fok = 1'b0;
		case (phase_q)
			msp_pkg::PH_IDLE:   ok = (rx_byte == msp_pkg::CH_DOLLAR);
			msp_pkg::PH_DOLLAR: ok = (rx_byte == msp_pkg::CH_M);
			msp_pkg::PH_M:      ok = (rx_byte inside {msp_pkg::CH_LT, msp_pkg::CH_GT});
			msp_pkg::PH_ARROW:  ok = (rx_byte <= max_len_q);
			msp_pkg::PH_LENGTH: ok = 1'b1;
			msp_pkg::PH_BODY: begin
				if (offset_q < len_q) begin
					pv = 1'b1;
					ok = 1'b1;
				end else if (xor_q == rx_byte) begin
					fok = 1'b1;
					ok  = 1'b1;
				end
			end
			default: ok = 1'b0;
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (!ok) begin
			phase_d = msp_pkg::PH_IDLE;
		end else begin
			case (phase_q)
				msp_pkg::PH_IDLE:   phase_d = msp_pkg::PH_DOLLAR;
				msp_pkg::PH_DOLLAR: phase_d = msp_pkg::PH_M;
				msp_pkg::PH_M:      phase_d = msp_pkg::PH_ARROW;
				msp_pkg::PH_ARROW:  phase_d = msp_pkg::PH_LENGTH;
				msp_pkg::PH_LENGTH: phase_d = msp_pkg::PH_BODY;
				msp_pkg::PH_BODY:   phase_d = fok ? msp_pkg::PH_IDLE : msp_pkg::PH_BODY;
				default:            phase_d = msp_pkg::PH_IDLE;
			endcase
		end
	end

	// data registers and result
	always_comb begin
		reply_d  = reply_q;
		len_d    = len_q;
		offset_d = offset_q;
		xor_d    = xor_q;
		cmd_d    = cmd_q;
		good_d   = good_q;
		bad_d    = ok ? bad_q : bad_q + 16'd1;
		case (phase_q)
			msp_pkg::PH_M: begin
				if (ok) reply_d = (rx_byte == msp_pkg::CH_GT);
			end
			msp_pkg::PH_ARROW: begin
				if (ok) begin
					len_d    = rx_byte;
					offset_d = 8'd0;
					xor_d    = rx_byte;
				end
			end
			msp_pkg::PH_LENGTH: begin
				cmd_d = rx_byte;
				xor_d = xor_q ^ rx_byte;
			end
			msp_pkg::PH_BODY: begin
				if (pv) begin
					offset_d = offset_q + 8'd1;
					xor_d    = xor_q ^ rx_byte;
				end
				if (fok) good_d = good_q + 16'd1;
			end
			default: ;
		endcase

		res.accepted        = ok;
		res.frame_error     = !ok;
		res.payload_valid   = pv;
		res.payload_byte    = pv ? rx_byte : 8'd0;
		res.payload_index   = pv ? offset_q : 8'd0;
		res.payload_length  = len_d;
		res.command_code    = cmd_d;
		res.packet_is_reply = reply_d;
		res.frame_ok        = fok;
		res.frames_received = good_d;
		res.errors_seen     = bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= msp_pkg::PH_IDLE;
			reply_q  <= 1'b0;
			len_q    <= 8'd0;
			offset_q <= 8'd0;
			xor_q    <= 8'd0;
			cmd_q    <= 8'd0;
			good_q   <= 16'd0;
			bad_q    <= 16'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			reply_q  <= reply_d;
			len_q    <= len_d;
			offset_q <= offset_d;
			xor_q    <= xor_d;
			cmd_q    <= cmd_d;
			good_q   <= good_d;
			bad_q    <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= msp_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

endmodule

/* sv/msp_out_reg.sv */
// Result register: holds one packed result until the master side takes it.
// Depends on msp_pkg.
module msp_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  msp_pkg::result_t           res,
	input  logic                       m_tready,
	output logic                       m_tvalid,
	output logic [msp_pkg::OUT_W-1:0]  m_tdata
);

	logic [msp_pkg::OUT_W-1:0] data_s2;
	logic                      valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// struct packs with accepted in bit 0
	always_ff @(posedge clk) begin
		if (load) data_s2 <= {{(msp_pkg::OUT_W - msp_pkg::OUT_BITS){1'b0}}, res};
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

endmodule

/* sv/msp_frame_parser.sv */
// Top level of the MSP v1 frame parser: input register, step logic, result register.
// Depends on msp_pkg, msp_core, msp_out_reg and assert_macros.svh.
//
// Usage:
//  The slave channel takes one serial byte per item in s_tdata. The master
//  channel gives one result item for every byte: grammar verdict, payload
//  byte and index, frame header fields, frame_ok and the two 16-bit counters.
//  Payload items must be dropped downstream unless frame_ok follows.
//  cfg_we/cfg_data write the maximum payload length (reset 255); write only
//  while no item is in flight.
//  Path: a byte is held in the input register, and its result in the result
//  register, which drives m_tvalid; the result register is loaded only when
//  it is empty or its result is taken in the same cycle.
//  Throughput: one item per cycle while the master side does not stall.
//  When the master side stalls, the result register holds; the input
//  register takes an item only while empty, and s_tready stays low once full.
//  Reset clears the parser to idle, zeroes both counters and empties the
//  pipeline.
`include "assert_macros.svh"

module msp_frame_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [7:0]                cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,  // [7:0] rx_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [0] accepted, [1] frame_error, [2] payload_valid, [10:3] payload_byte,
	// [18:11] payload_index, [26:19] payload_length, [34:27] command_code,
	// [35] packet_is_reply, [36] frame_ok, [52:37] frames_received,
	// [68:53] errors_seen, [71:69] zero
	output logic [msp_pkg::OUT_W-1:0] m_tdata
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	msp_pkg::result_t res;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) byte_s1 <= s_tdata;
	end

	msp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	msp_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.res     (res),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata)
	);

	// exactly one verdict per result
	`MSP_ASSERT_IMP(a_verdict, m_tvalid, m_tdata[0] != m_tdata[1], "accepted/frame_error clash")
	// a frame end is never also a payload byte
	`MSP_ASSERT_IMP(a_fok_excl, m_tvalid && m_tdata[36], m_tdata[0] && !m_tdata[2],
		"frame_ok on a payload or rejected byte")
	// payload index stays below the frame length
	`MSP_ASSERT_IMP(a_pidx, m_tvalid && m_tdata[2], m_tdata[18:11] < m_tdata[26:19],
		"payload index beyond length")
	// a stalled full pipeline keeps the input side closed
	`MSP_ASSERT_NEXT(a_stall, valid_s1 && m_tvalid && !m_tready, valid_s1,
		"input item lost during stall")

endmodule
